[hdl/qte_pkg.sv]
// Shared types, constants and the CORDIC angle table for the quaternion to Euler converter.
package qte_pkg;

    localparam int QW            = 16;             // quaternion component width
    localparam int PROD_W        = 32;             // 16x16 product width
    localparam int PW            = 34;             // atan2 argument width (Q2.30 and growth)
    localparam int SW            = 32;             // clamped asin argument width
    localparam int SQW           = 62;             // square root radicand / root width
    localparam int SQ_STEPS      = 31;             // one root bit per step
    localparam int CW            = 38;             // CORDIC x/y width
    localparam int ZW            = 26;             // angle accumulator, degrees * 65536
    localparam int ANG_LEN       = 24;             // entries in the angle table
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DEG90_Q16     = 90 * 65536;
    localparam int ROLL_LIM      = 23040;
    localparam int PITCH_LIM     = 11520;

    typedef struct packed {
        logic [SQW-1:0] n;
        logic [SQW-1:0] r;
    } qte_sq_t;

    typedef struct packed {
        logic signed [PW-1:0] rn;
        logic signed [PW-1:0] rd;
        logic signed [PW-1:0] yn;
        logic signed [PW-1:0] yd;
        logic signed [SW-1:0] s;
        logic                 clamped;
    } qte_side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } qte_lane_t;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/qte_sqrt_cell.sv]
// One digit step of the restoring integer square root.
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  qte_sq_t din,
    output qte_sq_t dout
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * STEP);

    logic [SQW-1:0] rb;
    qte_sq_t        dout_next;
    qte_sq_t        dout_reg;

    always_comb
    begin
        rb = din.r + BIT;
        if (din.n >= rb)
        begin
            dout_next.n = din.n - rb;
            dout_next.r = (din.r >> 1) + BIT;
        end
        else
        begin
            dout_next.n = din.n;
            dout_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[hdl/qte_cordic_cell.sv]
// One vectoring CORDIC micro-rotation with its angle update.
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic      clk,
    input  logic      en,
    input  qte_lane_t din,
    output qte_lane_t dout
);

    localparam logic signed [ZW-1:0] ANG = ZW'(atan_entry(5'(STAGE)));

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    qte_lane_t            dout_next;
    qte_lane_t            dout_reg;

    always_comb
    begin
        xs = din.x >>> STAGE;
        ys = din.y >>> STAGE;
        dout_next.zero = din.zero;
        if (din.y > 0)
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + ANG;
        end
        else
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[hdl/quaternion_to_euler_angles_top.sv]
// Top level: quaternion to roll, pitch and yaw, fully pipelined.
//
// Takes one Q1.15 quaternion per transfer and returns roll, pitch and yaw in
// degrees * 128 plus a flag set when the asin argument was saturated to +-1.
// One quaternion is accepted every clock cycle while the pipe is not held. The
// stages are one product stage, one sum/clamp stage, one square stage, one
// radicand stage, 31 square root digit cells, one quadrant fold stage, then
// CORDIC_STAGES rotation cells (capped at ANG_LEN) for the three angles in
// parallel, and the output register. The whole pipe holds when a result is
// waiting and the sink is not ready.
module quaternion_to_euler_angles_top
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_deg, pitch_deg, yaw_deg, 1 bit pad
    output logic [0:0]  m_tuser    // pitch_clamped
);

    localparam int NS = (CORDIC_STAGES > ANG_LEN) ? ANG_LEN : CORDIC_STAGES;

    logic adv;

    // stage 1: products
    logic signed [QW-1:0]     qw, qx, qy, qz;
    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] wz_reg, xy_reg, wy_reg, zx_reg;
    logic                     v1_reg;

    // stage 2: arguments
    qte_side_t            side2_next, side2_reg;
    logic                 v2_reg;
    logic signed [PW-1:0] s_raw;

    // stage 3: square
    qte_side_t            side3_reg;
    logic [63:0]          sq_reg;
    logic                 v3_reg;

    // root chain
    qte_sq_t   sq_stage [0:SQ_STEPS];
    qte_side_t side_reg [0:SQ_STEPS];
    logic      vsq_reg  [0:SQ_STEPS];

    // CORDIC chain
    qte_lane_t lane_r [0:NS];
    qte_lane_t lane_p [0:NS];
    qte_lane_t lane_y [0:NS];
    logic      vcd_reg [0:NS];
    logic      clp_reg [0:NS];

    logic signed [CW-1:0] c_arg;

    logic                 m_valid_reg;
    logic [47:0]          m_data_reg;
    logic                 m_user_reg;
    logic signed [16:0]   roll_d, pitch_d, yaw_d;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    always_comb
    begin
        side2_next.rn = (PW'(wx_reg) + PW'(yz_reg)) <<< 1;
        side2_next.rd = (PW'(1) <<< 30) - ((PW'(xx_reg) + PW'(yy_reg)) <<< 1);
        side2_next.yn = (PW'(wz_reg) + PW'(xy_reg)) <<< 1;
        side2_next.yd = (PW'(1) <<< 30) - ((PW'(yy_reg) + PW'(zz_reg)) <<< 1);
        s_raw         = (PW'(wy_reg) - PW'(zx_reg)) <<< 1;
        if (s_raw > (PW'(1) <<< 30))
        begin
            side2_next.s       = SW'(1) <<< 30;
            side2_next.clamped = 1'b1;
        end
        else if (s_raw < -(PW'(1) <<< 30))
        begin
            side2_next.s       = -(SW'(1) <<< 30);
            side2_next.clamped = 1'b1;
        end
        else
        begin
            side2_next.s       = SW'(s_raw);
            side2_next.clamped = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sq_reg    <= side2_reg.s * side2_reg.s;
            side_reg[0]   <= side3_reg;
            sq_stage[0].n <= (SQW'(1) << 60) - sq_reg[SQW-1:0];
            sq_stage[0].r <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            vsq_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg     <= s_tvalid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            vsq_reg[0] <= v3_reg;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        qte_sqrt_cell #(.STEP(k)) u_cell (
            .clk  (clk),
            .en   (adv),
            .din  (sq_stage[k]),
            .dout (sq_stage[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vsq_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vsq_reg[k+1] <= vsq_reg[k];
            end
        end
    end

    // quadrant fold into the right half plane
    function automatic qte_lane_t fold(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
        qte_lane_t l;
        l.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            if (y >= 0)
            begin
                l.x = y;
                l.y = -x;
                l.z = ZW'(DEG90_Q16);
            end
            else
            begin
                l.x = -y;
                l.y = x;
                l.z = -ZW'(DEG90_Q16);
            end
        end
        else
        begin
            l.x = x;
            l.y = y;
            l.z = '0;
        end
        return l;
    endfunction

    assign c_arg = CW'(sq_stage[SQ_STEPS].r[30:0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_r[0]  <= fold(CW'(side_reg[SQ_STEPS].rn), CW'(side_reg[SQ_STEPS].rd));
            lane_p[0]  <= fold(CW'(side_reg[SQ_STEPS].s), c_arg);
            lane_y[0]  <= fold(CW'(side_reg[SQ_STEPS].yn), CW'(side_reg[SQ_STEPS].yd));
            clp_reg[0] <= side_reg[SQ_STEPS].clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcd_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vcd_reg[0] <= vsq_reg[SQ_STEPS];
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        qte_cordic_cell #(.STAGE(i)) u_roll (
            .clk (clk), .en (adv), .din (lane_r[i]), .dout (lane_r[i+1])
        );
        qte_cordic_cell #(.STAGE(i)) u_pitch (
            .clk (clk), .en (adv), .din (lane_p[i]), .dout (lane_p[i+1])
        );
        qte_cordic_cell #(.STAGE(i)) u_yaw (
            .clk (clk), .en (adv), .din (lane_y[i]), .dout (lane_y[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                clp_reg[i+1] <= clp_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vcd_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vcd_reg[i+1] <= vcd_reg[i];
            end
        end
    end

    // round half up to degrees * 128, then saturate; a zero vector gives zero
    function automatic logic signed [16:0] to_deg(input qte_lane_t l, input int lim);
        logic signed [ZW:0]  t;
        logic signed [17:0]  d;
        logic signed [17:0]  lm;
        logic signed [16:0]  res;
        t  = (ZW+1)'(l.z) + (ZW+1)'(256);
        d  = 18'(t >>> 9);
        lm = 18'(lim);
        if (l.zero)
        begin
            res = '0;
        end
        else if (d > lm)
        begin
            res = 17'(lm);
        end
        else if (d < -lm)
        begin
            res = 17'(-lm);
        end
        else
        begin
            res = 17'(d);
        end
        return res;
    endfunction

    assign roll_d  = to_deg(lane_r[NS], ROLL_LIM);
    assign pitch_d = to_deg(lane_p[NS], PITCH_LIM);
    assign yaw_d   = to_deg(lane_y[NS], ROLL_LIM);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {1'b0, yaw_d[15:0], pitch_d[14:0], roll_d[15:0]};
            m_user_reg <= clp_reg[NS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= vcd_reg[NS];
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd11520 &&
                      $signed(m_tdata[30:16]) >= -15'sd11520))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040 &&
                      $signed(m_tdata[15:0]) >= -16'sd23040))
        else $error("roll out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

endmodule
